@@ rtl/core/sidalloc_pkg.sv @@
// ----------------------------------------------------------------------------
// sidalloc_pkg
// Shared constants, codes and types of the session id allocator.
// ----------------------------------------------------------------------------
package sidalloc_pkg;

  localparam int MAX_SESSIONS_DEF = 1024;
  localparam int ID_SPACE         = 1024;
  localparam int RESERVED_DEF     = 128;

  localparam int OP_W   = 2;
  localparam int ID_W   = 10;
  localparam int CNT_W  = 11;
  localparam int SEQ_W  = 32;

  // bitmap row geometry
  localparam int WORD_W = 16;
  localparam int BIT_W  = 4;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN_RSV = 2'd0,
    OP_OPEN_ANY = 2'd1,
    OP_CLOSE    = 2'd2,
    OP_STAMP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EVAL,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             status;
    logic [ID_W-1:0]  rid;
    logic [SEQ_W-1:0] seq;
  } result_t;

endpackage

@@ rtl/core/session_id_allocator_top.sv @@
// ----------------------------------------------------------------------------
// session_id_allocator_top
// Session id table: reserved and dynamic ranges, open/close/stamp requests.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  s_*     | in  | s_tvalid / s_tready   | s_tdata: op, sid
//  m_*     | out | m_tvalid / m_tready   | m_tdata: status, result_id, sequence_res
//  cfg_*   | in  | cfg_valid / cfg_ready | cfg_data: reserved_count
//
// Open reserved, close and stamp pass through accept, memory read, update and result.
// Open any reads one 16-bit bitmap row per cycle until a free id turns up or the
// last row of the search window is read; a full or empty range skips the scan.
// Reset and a cfg write clear the per-row valid flops at once; no clearing pass.
// A finished request waits in the output register while the next one is taken;
// it stalls in its result state only while that register is full and not taken.
module session_id_allocator_top #(
  parameter int MAX_SESSIONS = sidalloc_pkg::MAX_SESSIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sidalloc_pkg::S_TDATA_W-1:0] s_tdata,  // [1:0] op, [11:2] sid
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sidalloc_pkg::M_TDATA_W-1:0] m_tdata,  // [0] status, [10:1] result_id,
                                                       // [42:11] sequence_res
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sidalloc_pkg::ID_W-1:0]      cfg_data  // reserved_count
);
  import sidalloc_pkg::*;

  localparam int END     = (MAX_SESSIONS < ID_SPACE) ? MAX_SESSIONS : ID_SPACE;
  localparam int WORDS   = (END + WORD_W - 1) / WORD_W;
  localparam int WAW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW      = $clog2(END);
  localparam int RSV_RST = (RESERVED_DEF < END) ? RESERVED_DEF : END;
  localparam logic [CNT_W-1:0] END_C = CNT_W'(END);
  localparam logic [CNT_W-1:0] RSV_C = CNT_W'(RSV_RST);

  state_t state, state_next;

  op_t              op_q;
  logic [ID_W-1:0]  id_q;
  logic [CNT_W-1:0] lo, top, dcount;
  logic [CNT_W-1:0] top_next, dcount_next;

  // scan control
  logic [WAW-1:0]   scan_w, d_w, first_w, last_w;
  logic [BIT_W-1:0] first_b, last_b;
  logic             iss_done, d_v;

  // valid bitmap memory
  logic [WORD_W-1:0] bmap [2**WAW];
  logic [2**WAW-1:0] rowv;
  logic [WORD_W-1:0] bm_rdata;
  logic              bm_rvalid;
  logic              bm_re, bm_we;
  logic [WAW-1:0]    bm_ra, bm_wa;
  logic [WORD_W-1:0] bm_wd;

  // sequence memory
  logic [SEQ_W-1:0] seqm [2**IW];
  logic [SEQ_W-1:0] sq_rdata;
  logic             sq_re, sq_we;
  logic [IW-1:0]    sq_ra, sq_wa;
  logic [SEQ_W-1:0] sq_wd;

  result_t res, res_next, out_q;
  logic    out_valid;

  logic             s_acc, cfg_acc, out_free;
  logic [CNT_W-1:0] id_x, cfg_x, cfg_lo;
  logic [WORD_W-1:0] eff, id_mask, range_mask, free_bits;
  logic             cur_bit, found;
  logic [BIT_W-1:0] fbit;
  logic [ID_W-1:0]  fid;
  logic [WAW-1:0]   id_w;
  logic [CNT_W-1:0] span, from_v, to_v, to_m1, newc, newtop;
  logic             avail, sparse, nonempty;

  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_q.seq, out_q.rid, out_q.status});

  assign cfg_x  = {1'b0, cfg_data};
  assign cfg_lo = (cfg_x < END_C) ? cfg_x : END_C;

  assign id_x    = {1'b0, id_q};
  assign id_w    = id_q[WAW+BIT_W-1:BIT_W];
  assign id_mask = WORD_W'(1) << id_q[BIT_W-1:0];
  assign eff     = bm_rvalid ? bm_rdata : '0;
  assign cur_bit = eff[id_q[BIT_W-1:0]];

  // open-any search window
  assign span     = END_C - lo;
  assign avail    = dcount < span;
  assign sparse   = (top >= lo) && (dcount < (top - lo));
  assign from_v   = sparse ? lo : top;
  assign to_v     = sparse ? top : END_C;
  assign nonempty = from_v < to_v;
  assign to_m1    = to_v - CNT_W'(1);

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      range_mask[b] = ((d_w != first_w) || (BIT_W'(b) >= first_b)) &&
                      ((d_w != last_w)  || (BIT_W'(b) <= last_b));
    end
  end

  assign free_bits = ~eff & range_mask;
  assign found     = |free_bits;

  // lowest free bit
  always_comb begin
    fbit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) fbit = BIT_W'(b);
    end
  end

  assign fid    = ID_W'({d_w, fbit});
  assign newc   = dcount + CNT_W'(1);
  assign newtop = (top < (newc + lo)) ? (newc + lo) : top;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_acc) state_next = ST_ISSUE;
      ST_ISSUE: begin
        if (op_q == OP_OPEN_ANY) state_next = (avail && nonempty) ? ST_SCAN : ST_FIN;
        else                     state_next = ST_EVAL;
      end
      ST_EVAL:  state_next = ST_FIN;
      ST_SCAN:  if (d_v && (found || d_w == last_w)) state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory controls and update values
  always_comb begin
    bm_re = 1'b0; bm_ra = id_w;
    bm_we = 1'b0; bm_wa = id_w; bm_wd = eff;
    sq_re = 1'b0; sq_ra = id_q[IW-1:0];
    sq_we = 1'b0; sq_wa = id_q[IW-1:0]; sq_wd = '0;
    res_next    = res;
    dcount_next = dcount;
    top_next    = top;
    unique case (state)
      ST_ISSUE: begin
        if (op_q != OP_OPEN_ANY) begin
          bm_re = 1'b1;
          sq_re = (op_q == OP_STAMP);
        end else begin
          res_next = '{status: 1'b1, rid: '0, seq: '0};
        end
      end
      ST_EVAL: begin
        res_next = '{status: 1'b1, rid: id_q, seq: '0};
        unique case (op_q)
          OP_OPEN_RSV: begin
            if (id_x < lo && !cur_bit) begin
              bm_we = 1'b1;
              bm_wd = eff | id_mask;
              sq_we = 1'b1;
              res_next.status = 1'b0;
            end
          end
          OP_CLOSE: begin
            if (id_x < top) begin
              res_next.status = 1'b0;
              if (cur_bit) begin
                bm_we = 1'b1;
                bm_wd = eff & ~id_mask;
                // reserved ids leave the count and top alone
                if (id_x >= lo) begin
                  if (dcount != '0) dcount_next = dcount - CNT_W'(1);
                  if (id_x + CNT_W'(1) == top) top_next = top - CNT_W'(1);
                end
              end
            end
          end
          OP_STAMP: begin
            if (id_x < top && cur_bit) begin
              sq_we = 1'b1;
              sq_wd = sq_rdata + SEQ_W'(1);
              res_next.status = 1'b0;
              res_next.seq    = sq_rdata;
            end
          end
          OP_OPEN_ANY: ;
        endcase
      end
      ST_SCAN: begin
        bm_re = !iss_done;
        bm_ra = scan_w;
        if (d_v && found) begin
          bm_we = 1'b1;
          bm_wa = d_w;
          bm_wd = eff | (WORD_W'(1) << fbit);
          sq_we = 1'b1;
          sq_wa = fid[IW-1:0];
          dcount_next = newc;
          top_next    = newtop;
          res_next    = '{status: 1'b0, rid: fid, seq: '0};
        end else if (d_v && d_w == last_w) begin
          res_next = '{status: 1'b1, rid: '0, seq: '0};
        end
      end
      default: ;
    endcase
  end

  // bitmap: registered read, row valid flops mask stale rows
  always_ff @(posedge clk) begin
    if (bm_we) bmap[bm_wa] <= bm_wd;
    if (bm_re) begin
      bm_rdata  <= bmap[bm_ra];
      bm_rvalid <= rowv[bm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_we) seqm[sq_wa] <= sq_wd;
    if (sq_re) sq_rdata <= seqm[sq_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lo        <= RSV_C;
      top       <= RSV_C;
      dcount    <= '0;
      rowv      <= '0;
      out_valid <= 1'b0;
      d_v       <= 1'b0;
      iss_done  <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        lo     <= cfg_lo;
        top    <= cfg_lo;
        dcount <= '0;
        rowv   <= '0;
      end else begin
        top    <= top_next;
        dcount <= dcount_next;
        if (bm_we) rowv[bm_wa] <= 1'b1;
      end

      if (state == ST_FIN && out_free) out_valid <= 1'b1;
      else if (m_tready)               out_valid <= 1'b0;

      if (state == ST_ISSUE) begin
        iss_done <= 1'b0;
        d_v      <= 1'b0;
      end else if (state == ST_SCAN && !iss_done) begin
        d_v      <= 1'b1;
        iss_done <= (scan_w == last_w);
      end else begin
        d_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      op_q <= op_t'(s_tdata[OP_W-1:0]);
      id_q <= s_tdata[OP_W+ID_W-1:OP_W];
    end
    if (state == ST_ISSUE) begin
      scan_w  <= from_v[WAW+BIT_W-1:BIT_W];
      first_w <= from_v[WAW+BIT_W-1:BIT_W];
      first_b <= from_v[BIT_W-1:0];
      last_w  <= to_m1[WAW+BIT_W-1:BIT_W];
      last_b  <= to_m1[BIT_W-1:0];
    end else if (state == ST_SCAN && !iss_done) begin
      d_w    <= scan_w;
      scan_w <= scan_w + WAW'(1);
    end
    res <= res_next;
    if (state == ST_FIN && out_free) out_q <= res;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    dcount <= (END_C - lo))
    else $error("dynamic count exceeds dynamic range");

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    (top >= lo) && (top <= END_C))
    else $error("top mark outside boundary and table end");

  a_scan_op: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (op_q == OP_OPEN_ANY))
    else $error("bitmap scan for a request that is not open any");

  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !out_valid) |=> out_valid)
    else $error("finished request not moved to output register");

endmodule
